### hdl/bnms_pkg.sv
// shared types and constants for the box nms engine
package bnms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int CW = 16;
    localparam int CLSW = 8;
    localparam int KEPTW = 7;

    localparam logic [0:0] REG_IOU = 1'b0;
    localparam logic [0:0] REG_MAXK = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_OUT_RD,
        ST_OUT_CHK,
        ST_SUP_RD,
        ST_SUP_CHK,
        ST_SUP_WAIT,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic        latch_in;
        logic        rd_en;
        logic        wr_en;
        logic        wr_from_in;
        logic        cur_load;
        logic        mark_set;
        logic        marks_clear;
        logic        emit;
        logic        emit_last;
        logic        iou_start;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic        rd_ge;
        logic        rd_marked;
        logic        same_class;
        logic        iou_done;
        logic        iou_hit;
    } dp_stat_t;

endpackage

### hdl/bnms_ram.sv
// generic ram with one write port and one registered read port
module bnms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

### hdl/bnms_iou.sv
// multi-cycle iou overlap test by cross multiplication
module bnms_iou (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] box_a,
    input  logic [63:0] box_b,
    input  logic [15:0] thr,
    output logic        done,
    output logic        hit
);
    import bnms_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [16:0] iw_reg, ih_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic [33:0] inter_reg, area_a_reg, area_b_reg;
    logic [35:0] uni_reg;
    logic [51:0] lhs_reg;
    logic [51:0] rhs_reg;

    function automatic logic [16:0] span(input logic signed [15:0] lo,
                                         input logic signed [15:0] hi);
        logic signed [16:0] d;
        d = 17'(hi) - 17'(lo);
        return (hi > lo) ? 17'(d) : 17'd0;
    endfunction

    logic signed [15:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [15:0] ix1, iy1, ix2, iy2;
    assign ax1 = box_a[15:0];
    assign ay1 = box_a[31:16];
    assign ax2 = box_a[47:32];
    assign ay2 = box_a[63:48];
    assign bx1 = box_b[15:0];
    assign by1 = box_b[31:16];
    assign bx2 = box_b[47:32];
    assign by2 = box_b[63:48];
    assign ix1 = (ax1 > bx1) ? ax1 : bx1;
    assign iy1 = (ay1 > by1) ? ay1 : by1;
    assign ix2 = (ax2 < bx2) ? ax2 : bx2;
    assign iy2 = (ay2 < by2) ? ay2 : by2;

    always_comb
    begin
        step_next = step_reg;
        if (start)
        begin
            step_next = 3'd1;
        end
        else if (step_reg != 3'd0)
        begin
            step_next = (step_reg == 3'd5) ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    // spans latched on start, step 1 products, 2 union, 3 cross products; hit compares them combinationally
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            iw_reg <= span(ix1, ix2);
            ih_reg <= span(iy1, iy2);
            aw_reg <= span(ax1, ax2);
            ah_reg <= span(ay1, ay2);
            bw_reg <= span(bx1, bx2);
            bh_reg <= span(by1, by2);
        end
        if (step_reg == 3'd1)
        begin
            inter_reg  <= iw_reg * ih_reg;
            area_a_reg <= aw_reg * ah_reg;
            area_b_reg <= bw_reg * bh_reg;
        end
        if (step_reg == 3'd2)
        begin
            uni_reg <= 36'(area_a_reg) + 36'(area_b_reg) - 36'(inter_reg);
        end
        if (step_reg == 3'd3)
        begin
            lhs_reg <= {inter_reg, 16'd0} + 52'd0;
            rhs_reg <= 52'(uni_reg[34:0]) * 52'(thr);
        end
    end

    // union never goes negative since inter is bounded by each area
    assign done = (step_reg == 3'd4);
    assign hit  = (uni_reg != 36'd0) && (lhs_reg > rhs_reg);
endmodule

### hdl/bnms_datapath.sv
// datapath: box stores, suppression marks, iou unit and result registers
module bnms_datapath #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  bnms_pkg::dp_cmd_t            cmd,
    input  logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    input  logic [$clog2(MAX_BOXES)-1:0] wr_addr,
    input  logic                         ovf,
    input  logic [15:0]                  iou_thr,
    input  logic signed [15:0]           box_x1,
    input  logic signed [15:0]           box_y1,
    input  logic signed [15:0]           box_x2,
    input  logic signed [15:0]           box_y2,
    input  logic [15:0]                  score,
    input  logic [7:0]                   box_class,
    output bnms_pkg::dp_stat_t           stat,
    output logic                         keep_valid,
    output logic signed [15:0]           keep_x1,
    output logic signed [15:0]           keep_y1,
    output logic signed [15:0]           keep_x2,
    output logic signed [15:0]           keep_y2,
    output logic [15:0]                  keep_score,
    output logic [7:0]                   keep_class,
    output logic                         last_kept,
    output logic                         overflowed
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);

    logic [63:0] in_c_reg;
    logic [23:0] in_sc_reg;
    logic [63:0] rd_c;
    logic [23:0] rd_sc;
    logic [63:0] cur_c_reg;
    logic [23:0] cur_sc_reg;
    logic [MAX_BOXES-1:0] marks_reg;
    logic [AW-1:0] rd_addr_q_reg;
    logic iou_done, iou_hit;
    logic kv_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_c_reg  <= {box_y2, box_x2, box_y1, box_x1};
            in_sc_reg <= {box_class, score};
        end
        if (cmd.cur_load)
        begin
            cur_c_reg  <= rd_c;
            cur_sc_reg <= rd_sc;
        end
        if (cmd.rd_en)
        begin
            rd_addr_q_reg <= rd_addr;
        end
        // the kept box stays in the cur registers through its suppression pass
        if (cmd.emit)
        begin
            {keep_y2, keep_x2, keep_y1, keep_x1} <= cur_c_reg;
            {keep_class, keep_score} <= cur_sc_reg;
            last_kept  <= cmd.emit_last;
            overflowed <= ovf;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
            kv_reg    <= 1'b0;
        end
        else
        begin
            kv_reg <= cmd.emit;
            if (cmd.marks_clear)
            begin
                marks_reg <= '0;
            end
            else if (cmd.mark_set)
            begin
                marks_reg[rd_addr_q_reg] <= 1'b1;
            end
        end
    end

    bnms_ram #(.WIDTH(64), .DEPTH(MAX_BOXES)) u_coord (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(wr_addr),
        .wr_data(cmd.wr_from_in ? in_c_reg : rd_c),
        .rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(rd_c)
    );

    bnms_ram #(.WIDTH(24), .DEPTH(MAX_BOXES)) u_score (
        .clk(clk), .wr_en(cmd.wr_en), .wr_addr(wr_addr),
        .wr_data(cmd.wr_from_in ? in_sc_reg : rd_sc),
        .rd_en(cmd.rd_en), .rd_addr(rd_addr), .rd_data(rd_sc)
    );

    bnms_iou u_iou (
        .clk(clk), .rst_n(rst_n), .start(cmd.iou_start),
        .box_a(cur_c_reg), .box_b(rd_c), .thr(iou_thr),
        .done(iou_done), .hit(iou_hit)
    );

    assign stat.rd_ge      = (rd_sc[15:0] >= in_sc_reg[15:0]);
    assign stat.rd_marked  = marks_reg[rd_addr_q_reg];
    assign stat.same_class = (rd_sc[23:16] == cur_sc_reg[23:16]);
    assign stat.iou_done   = iou_done;
    assign stat.iou_hit    = iou_hit;
    assign keep_valid      = kv_reg;
endmodule

### hdl/bnms_ctrl.sv
// controller: insertion sort walk and greedy suppression sequencing
module bnms_ctrl #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         last_box,
    input  logic [6:0]                   max_kept_cfg,
    input  bnms_pkg::dp_stat_t           stat,
    output logic                         busy,
    output bnms_pkg::dp_cmd_t            cmd,
    output logic [$clog2(MAX_BOXES)-1:0] rd_addr,
    output logic [$clog2(MAX_BOXES)-1:0] wr_addr,
    output logic                         ovf
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);
    localparam int CNTW = $clog2(MAX_BOXES + 1);

    state_t state_reg, state_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] pos_reg, pos_next;   // scan position / outer index
    logic [CNTW-1:0] j_reg, j_next;       // shift / inner index
    logic [6:0] emitted_reg, emitted_next;
    logic last_reg, last_next;
    logic ovf_reg, ovf_next;
    logic live_reg, live_next;            // a later box survived this pass
    logic [6:0] limit;
    logic [CNTW-1:0] nxt_live;

    assign limit = (max_kept_cfg == 7'd0) ? 7'd1 :
                   (max_kept_cfg > 7'd64) ? 7'd64 : max_kept_cfg;
    assign ovf  = ovf_reg;
    assign busy = (state_reg != ST_IDLE);
    assign nxt_live = pos_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        j_next       = j_reg;
        emitted_next = emitted_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        live_next    = live_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    last_next = last_box;
                    pos_next  = '0;
                    if (count_reg >= CNTW'(MAX_BOXES))
                    begin
                        ovf_next   = 1'b1;
                        state_next = last_box ? ST_OUT_RD : ST_IDLE;
                        pos_next   = '0;
                        emitted_next = 7'd0;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_INSERT : ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.rd_ge)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = (pos_reg + 1'b1 == count_reg) ? ST_INSERT : ST_SCAN_RD;
                end
                else
                begin
                    j_next     = count_reg;
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                state_next = (j_reg == pos_reg) ? ST_INSERT : ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                j_next     = j_reg - 1'b1;
                state_next = ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                count_next   = count_reg + 1'b1;
                pos_next     = '0;
                emitted_next = 7'd0;
                state_next   = last_reg ? ST_OUT_RD : ST_IDLE;
            end
            ST_OUT_RD:
            begin
                if (pos_reg >= count_reg || emitted_reg >= limit)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_OUT_CHK;
                end
            end
            ST_OUT_CHK:
            begin
                if (stat.rd_marked)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    emitted_next = emitted_reg + 7'd1;
                    j_next       = nxt_live;
                    live_next    = 1'b0;
                    state_next   = ST_SUP_RD;
                end
            end
            ST_SUP_RD:
            begin
                if (j_reg >= count_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_SUP_CHK;
                end
            end
            ST_SUP_CHK:
            begin
                if (stat.rd_marked || !stat.same_class)
                begin
                    if (!stat.rd_marked)
                    begin
                        live_next = 1'b1;
                    end
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SUP_RD;
                end
                else
                begin
                    state_next = ST_SUP_WAIT;
                end
            end
            ST_SUP_WAIT:
            begin
                if (stat.iou_done)
                begin
                    if (!stat.iou_hit)
                    begin
                        live_next = 1'b1;
                    end
                    j_next     = j_reg + 1'b1;
                    state_next = ST_SUP_RD;
                end
            end
            ST_DONE:
            begin
                count_next = '0;
                ovf_next   = 1'b0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // a kept box goes out at the end of its suppression pass; it is the final
    // one when no later box survived the pass or the emit limit is reached
    always_comb
    begin
        cmd     = '0;
        rd_addr = '0;
        wr_addr = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.latch_in = start;
            end
            ST_SCAN_RD:
            begin
                cmd.rd_en = 1'b1;
                rd_addr   = pos_reg[AW-1:0];
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_en = (j_reg != pos_reg);
                rd_addr   = AW'(j_reg - 1'b1);
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_en = 1'b1;
                wr_addr   = j_reg[AW-1:0];
            end
            ST_INSERT:
            begin
                cmd.wr_en      = 1'b1;
                cmd.wr_from_in = 1'b1;
                wr_addr        = pos_reg[AW-1:0];
                cmd.marks_clear = 1'b1;
            end
            ST_OUT_RD:
            begin
                cmd.rd_en = 1'b1;
                rd_addr   = pos_reg[AW-1:0];
            end
            ST_OUT_CHK:
            begin
                if (!stat.rd_marked)
                begin
                    cmd.cur_load = 1'b1;
                end
            end
            ST_SUP_RD:
            begin
                if (j_reg >= count_reg)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = !live_reg || (emitted_reg >= limit);
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = j_reg[AW-1:0];
                end
            end
            ST_SUP_CHK:
            begin
                if (!stat.rd_marked && stat.same_class)
                begin
                    cmd.iou_start = 1'b1;
                end
            end
            ST_SUP_WAIT:
            begin
                cmd.mark_set = stat.iou_done && stat.iou_hit;
            end
            ST_DONE:
            begin
                cmd.marks_clear = 1'b1;
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pos_reg     <= '0;
            j_reg       <= '0;
            emitted_reg <= 7'd0;
            last_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
            live_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            j_reg       <= j_next;
            emitted_reg <= emitted_next;
            last_reg    <= last_next;
            ovf_reg     <= ovf_next;
            live_reg    <= live_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(MAX_BOXES))
        else $error("stored count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        emitted_reg <= 7'd64)
        else $error("emitted count beyond limit");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |=> (count_reg == '0) && !ovf_reg)
        else $error("set not closed");
endmodule

### hdl/box_nms_engine.sv
// top level of the box nms engine
// boxes come in on the box ports: a box transaction is accepted at the rising
// edge where start is high and busy is low, one box at a time. each accepted
// box is insertion sorted into falling score order by walking the stored
// entries through the single read port of the box store.
// a box that arrives with the store full is dropped and marks the set.
// the box with last_box high closes the set: greedy suppression then walks
// the sorted store, with an iou test for each same-class entry, and each
// kept box comes out on keep_valid for one cycle, in falling score order,
// with last_kept on the final one.
// overflowed is high on every result of a set in which boxes were dropped.
// the receiver cannot stall; results are presented for one cycle only.
// the config channel (cfg_valid/cfg_ready) writes the iou threshold (index 0)
// and max_kept (index 1); it is always ready and must be written only while
// idle, which the block itself does not enforce.
// reset clears counts, flags and marks and restores the register defaults;
// box store contents are left undefined and never read before being written.
module box_nms_engine #(
    parameter int MAX_BOXES = bnms_pkg::MAX_BOXES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] box_x1,
    input  logic signed [15:0] box_y1,
    input  logic signed [15:0] box_x2,
    input  logic signed [15:0] box_y2,
    input  logic [15:0]        score,
    input  logic [7:0]         box_class,
    input  logic               last_box,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               keep_valid,
    output logic signed [15:0] keep_x1,
    output logic signed [15:0] keep_y1,
    output logic signed [15:0] keep_x2,
    output logic signed [15:0] keep_y2,
    output logic [15:0]        keep_score,
    output logic [7:0]         keep_class,
    output logic               last_kept,
    output logic               overflowed
);
    import bnms_pkg::*;

    localparam int AW = $clog2(MAX_BOXES);

    logic [15:0] iou_thr_reg;
    logic [6:0]  max_kept_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [AW-1:0] rd_addr, wr_addr;
    logic        ovf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iou_thr_reg  <= 16'd32768;
            max_kept_reg <= 7'd64;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_IOU:  iou_thr_reg  <= cfg_data;
                REG_MAXK: max_kept_reg <= cfg_data[6:0];
                default:  iou_thr_reg  <= iou_thr_reg;
            endcase
        end
    end

    bnms_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .last_box(last_box),
        .max_kept_cfg(max_kept_reg), .stat(stat), .busy(busy), .cmd(cmd),
        .rd_addr(rd_addr), .wr_addr(wr_addr), .ovf(ovf)
    );

    bnms_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .rd_addr(rd_addr),
        .wr_addr(wr_addr), .ovf(ovf), .iou_thr(iou_thr_reg),
        .box_x1(box_x1), .box_y1(box_y1), .box_x2(box_x2), .box_y2(box_y2),
        .score(score), .box_class(box_class), .stat(stat),
        .keep_valid(keep_valid), .keep_x1(keep_x1), .keep_y1(keep_y1),
        .keep_x2(keep_x2), .keep_y2(keep_y2), .keep_score(keep_score),
        .keep_class(keep_class), .last_kept(last_kept), .overflowed(overflowed)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        keep_valid |-> busy || $past(busy))
        else $error("result outside a set");
    // a closing box always starts work, even when it is dropped
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_box) |=> busy)
        else $error("closing box did not start work");
    assert property (@(posedge clk) disable iff (!rst_n)
        (keep_valid && last_kept) |=> !keep_valid)
        else $error("result after last kept");
endmodule
